// File: design/assert_macros.svh
// Assertion macros used by the reassembler core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every clock edge outside reset.
`define LPR_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define LPR_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define LPR_ASSERT(name, clk, rst_n, prop, msg)
`define LPR_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

// File: design/lpr_pkg.sv
// Types and constants of the link packet reassembler.
package lpr_pkg;

    localparam int BYTE_W   = 8;
    localparam int SEQ_W    = 8;
    localparam int HDR_W    = 3;
    localparam int LEN_W    = 32;
    localparam int CFG_W    = 15;
    localparam int OFFS_W   = 14;
    localparam int PBYTES_W = 15;

    // Length header is four bytes, little-endian.
    localparam logic [HDR_W-1:0] HDR_BYTES = 3'd4;

    // Buffer capacity after reset.
    localparam logic [CFG_W-1:0] CAP_RESET = 15'd16384;

    // One received word.
    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              frame_first;
        logic              frame_last;
    } t_in_word;

    // One result word.
    typedef struct packed {
        logic                write_valid;
        logic [BYTE_W-1:0]   write_byte;
        logic [OFFS_W-1:0]   write_offset;
        logic                packet_done;
        logic [PBYTES_W-1:0] packet_bytes;
        logic                out_of_sync;
        logic                overflow;
    } t_out_word;

endpackage

// File: design/lpr_in_stage.sv
// Input register stage: holds one received word for the core.
module lpr_in_stage import lpr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_word i_word,
    input  logic     i_advance,
    output logic     o_stall,
    output logic     o_valid,
    output t_in_word o_word
);

    logic     r_valid;
    t_in_word r_word;

    // Stall only while a held word cannot move on.
    assign o_stall = r_valid && !i_advance;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    // Payload, loaded on accept.
    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_word <= i_word;
        end
    end

endmodule

// File: design/lpr_core.sv
// Reassembly state and per-word logic: sequence check, header, offsets, completion.
`include "assert_macros.svh"

module lpr_core import lpr_pkg::*; #(
    parameter int MAX_PACKET_BYTES = 16384
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_fire,
    input  t_in_word         i_word,
    output logic             o_res_valid,
    output t_out_word        o_res_word
);

    // Capacity compare width covers both the register and the limit.
    localparam int LIM_W = $clog2(MAX_PACKET_BYTES + 1);
    localparam int CAP_W = (LIM_W > CFG_W) ? LIM_W : CFG_W;
    localparam logic [CAP_W-1:0] CAP_LIMIT = CAP_W'(MAX_PACKET_BYTES);

    logic [CFG_W-1:0]    r_capacity;
    logic [SEQ_W-1:0]    r_exp_seq,  n_exp_seq;
    logic [HDR_W-1:0]    r_hdr_cnt,  n_hdr_cnt;
    logic [LEN_W-1:0]    r_pkt_len,  n_pkt_len;
    logic [LEN_W-1:0]    r_rcv_cnt,  n_rcv_cnt;
    logic [CFG_W-1:0]    r_stored,   n_stored;
    logic                r_resync,   n_resync;
    logic                r_open,     n_open;

    logic [CAP_W-1:0]    cap;
    logic                wvalid;
    logic                done;
    logic                oos;
    logic                ovf;
    logic [CFG_W-1:0]    woff;
    logic [CFG_W-1:0]    pbytes;

    // Effective capacity is the lesser of the register and the limit.
    always_comb begin
        if (CAP_W'(r_capacity) < CAP_LIMIT) begin
            cap = CAP_W'(r_capacity);
        end else begin
            cap = CAP_LIMIT;
        end
    end

    // Next state and result flags for the word in the input register.
    always_comb begin
        n_exp_seq = r_exp_seq;
        n_hdr_cnt = r_hdr_cnt;
        n_pkt_len = r_pkt_len;
        n_rcv_cnt = r_rcv_cnt;
        n_stored  = r_stored;
        n_resync  = r_resync;
        n_open    = r_open;
        wvalid    = 1'b0;
        done      = 1'b0;
        oos       = 1'b0;
        ovf       = 1'b0;
        woff      = '0;
        pbytes    = '0;
        if (i_fire) begin
            if (i_word.frame_first) begin
                n_open = 1'b0;
                // While resyncing, only a frame with sequence zero is looked at.
                if (!(r_resync && (i_word.rx_byte != '0))) begin
                    n_resync = 1'b0;
                    if (i_word.rx_byte != r_exp_seq) begin
                        n_exp_seq = '0;
                        n_hdr_cnt = '0;
                        n_pkt_len = '0;
                        n_rcv_cnt = '0;
                        n_stored  = '0;
                        n_resync  = 1'b1;
                        oos       = 1'b1;
                    end else begin
                        n_exp_seq = r_exp_seq + 1'b1;
                        n_open    = 1'b1;
                    end
                end
            end else if (r_open) begin
                if (r_hdr_cnt < HDR_BYTES) begin
                    // Length header byte, least significant first.
                    n_pkt_len[8*r_hdr_cnt[1:0] +: 8] = i_word.rx_byte;
                    n_hdr_cnt = r_hdr_cnt + 1'b1;
                end else begin
                    // Data byte: count it, then store it if there is room.
                    if (r_rcv_cnt != '1) begin
                        n_rcv_cnt = r_rcv_cnt + 1'b1;
                    end
                    if (CAP_W'(r_stored) < cap) begin
                        wvalid   = 1'b1;
                        woff     = r_stored;
                        n_stored = r_stored + 1'b1;
                    end else begin
                        ovf = 1'b1;
                    end
                end
            end
            // Completion check at the end of an open frame.
            if (i_word.frame_last && n_open) begin
                n_open = 1'b0;
                if ((n_hdr_cnt == HDR_BYTES) && (n_rcv_cnt >= n_pkt_len)) begin
                    done      = 1'b1;
                    pbytes    = n_stored;
                    n_exp_seq = '0;
                    n_hdr_cnt = '0;
                    n_pkt_len = '0;
                    n_rcv_cnt = '0;
                    n_stored  = '0;
                end
            end
        end
    end

    // Result word, with unused fields held at zero.
    assign o_res_valid = wvalid || done || oos || ovf;
    always_comb begin
        o_res_word.write_valid  = wvalid;
        o_res_word.write_byte   = wvalid ? i_word.rx_byte : '0;
        o_res_word.write_offset = woff[OFFS_W-1:0];
        o_res_word.packet_done  = done;
        o_res_word.packet_bytes = PBYTES_W'(pbytes);
        o_res_word.out_of_sync  = oos;
        o_res_word.overflow     = ovf;
    end

    // Capacity register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_data;
        end
    end

    // Packet state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_seq <= '0;
            r_hdr_cnt <= '0;
            r_pkt_len <= '0;
            r_rcv_cnt <= '0;
            r_stored  <= '0;
            r_resync  <= 1'b0;
            r_open    <= 1'b0;
        end else begin
            r_exp_seq <= n_exp_seq;
            r_hdr_cnt <= n_hdr_cnt;
            r_pkt_len <= n_pkt_len;
            r_rcv_cnt <= n_rcv_cnt;
            r_stored  <= n_stored;
            r_resync  <= n_resync;
            r_open    <= n_open;
        end
    end

    // The header count never runs past the header length.
    `LPR_ASSERT(a_hdr_range, i_clk, i_rst_n, r_hdr_cnt <= HDR_BYTES, "header count out of range")
    // While resyncing the expected sequence stays at zero.
    `LPR_ASSERT(a_resync_seq, i_clk, i_rst_n, r_resync |-> (r_exp_seq == '0), "resync with nonzero sequence")
    // A sequence mismatch puts the block into resync.
    `LPR_ASSERT(a_oos_resync, i_clk, i_rst_n, (o_res_valid && oos) |=> r_resync, "mismatch without resync")
    // A finished packet leaves the counters cleared.
    `LPR_ASSERT(a_done_clear, i_clk, i_rst_n, (o_res_valid && done) |=> ((r_hdr_cnt == '0) && (r_rcv_cnt == '0) && (r_stored == '0)), "packet state not cleared after done")
    // Reset leaves no resync and no header in progress.
    `LPR_ASSERT_ALWAYS(a_reset_state, i_clk, !i_rst_n |=> (!r_resync && (r_hdr_cnt == '0) && !r_open), "state not cleared by reset")

endmodule

// File: design/lpr_out_stage.sv
// Output register stage: holds one result word until it is taken.
module lpr_out_stage import lpr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_res_valid,
    input  t_out_word i_res_word,
    input  logic      i_stall,
    output logic      o_ready,
    output logic      o_valid,
    output t_out_word o_word
);

    logic      r_valid;
    t_out_word r_word;

    // Room for a new result when empty or when the held word leaves now.
    assign o_ready = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_res_valid;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_res_valid) begin
            r_word <= i_res_word;
        end
    end

endmodule

// File: design/link_packet_reassembler.sv
// Path: an accepted byte is held in the input register; its result word is
// registered in the output register once that has room, and is then on the outputs.
// Throughput: one byte per cycle; the input stalls only while its register holds
// a byte and the output register is full and stalled.
// Reset: synchronous, active low; clears all packet state, the pipeline valids,
// and sets the buffer capacity to 16384. No clearing pass is needed.
module link_packet_reassembler import lpr_pkg::*; #(
    parameter int MAX_PACKET_BYTES = 16384
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CFG_W-1:0]    i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [BYTE_W-1:0]   i_rx_byte,
    input  logic                i_frame_first,
    input  logic                i_frame_last,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_write_valid,
    output logic [BYTE_W-1:0]   o_write_byte,
    output logic [OFFS_W-1:0]   o_write_offset,
    output logic                o_packet_done,
    output logic [PBYTES_W-1:0] o_packet_bytes,
    output logic                o_out_of_sync,
    output logic                o_overflow
);

    t_in_word  in_word;
    t_in_word  held_word;
    logic      held_valid;
    logic      out_ready;
    logic      fire;
    logic      res_valid;
    t_out_word res_word;
    t_out_word out_word;

    // Gather the input fields into one word.
    assign in_word.rx_byte     = i_rx_byte;
    assign in_word.frame_first = i_frame_first;
    assign in_word.frame_last  = i_frame_last;

    // The held word is processed when the output register has room.
    assign fire = held_valid && out_ready;

    lpr_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_word    (in_word),
        .i_advance (out_ready),
        .o_stall   (o_in_stall),
        .o_valid   (held_valid),
        .o_word    (held_word)
    );

    lpr_core #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_fire      (fire),
        .i_word      (held_word),
        .o_res_valid (res_valid),
        .o_res_word  (res_word)
    );

    lpr_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res_word  (res_word),
        .i_stall     (i_out_stall),
        .o_ready     (out_ready),
        .o_valid     (o_out_valid),
        .o_word      (out_word)
    );

    // Result fields to their ports.
    assign o_write_valid  = out_word.write_valid;
    assign o_write_byte   = out_word.write_byte;
    assign o_write_offset = out_word.write_offset;
    assign o_packet_done  = out_word.packet_done;
    assign o_packet_bytes = out_word.packet_bytes;
    assign o_out_of_sync  = out_word.out_of_sync;
    assign o_overflow     = out_word.overflow;

endmodule

// File: sim/tb_link_packet_reassembler.sv
// Testbench for the link packet reassembler: random and directed frames checked against a predictor.
`timescale 1ns / 100ps

module tb_link_packet_reassembler;
    import lpr_pkg::*;

    localparam logic [CFG_W-1:0] MAX_STORED = 15'd16384;

    // Clock, reset and all block inputs start at known values.
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_W-1:0]      i_cfg_data    = '0;
    logic                  i_in_valid    = 1'b0;
    logic [BYTE_W-1:0]     i_rx_byte     = '0;
    logic                  i_frame_first = 1'b0;
    logic                  i_frame_last  = 1'b0;
    logic                  i_out_stall   = 1'b0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic                  o_write_valid;
    logic [BYTE_W-1:0]     o_write_byte;
    logic [OFFS_W-1:0]     o_write_offset;
    logic                  o_packet_done;
    logic [PBYTES_W-1:0]   o_packet_bytes;
    logic                  o_out_of_sync;
    logic                  o_overflow;

    // Words waiting to be sent and results the predictor has produced.
    t_in_word  rx_frame_bytes[$];
    t_out_word predicted_results[$];
    t_in_word  next_word;
    t_out_word oldest_result;

    // Idle and stall rates, in percent, set per phase.
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int n_errors     = 0;

    // Predictor state of the reassembler.
    logic [CFG_W-1:0]    capacity_setting = CAP_RESET;
    logic [SEQ_W-1:0]    seq_expected     = '0;
    logic [HDR_W-1:0]    header_seen      = '0;
    logic [LEN_W-1:0]    length_field     = '0;
    logic [LEN_W-1:0]    data_received    = '0;
    logic [PBYTES_W-1:0] data_stored      = '0;
    logic                discarding       = 1'b0;
    logic                frame_active     = 1'b0;

    link_packet_reassembler uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_rx_byte      (i_rx_byte),
        .i_frame_first  (i_frame_first),
        .i_frame_last   (i_frame_last),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_write_valid  (o_write_valid),
        .o_write_byte   (o_write_byte),
        .o_write_offset (o_write_offset),
        .o_packet_done  (o_packet_done),
        .o_packet_bytes (o_packet_bytes),
        .o_out_of_sync  (o_out_of_sync),
        .o_overflow     (o_overflow)
    );

    always #5 i_clk = ~i_clk;

    // Drops all per-packet state, as a completed or abandoned packet does.
    function automatic void clear_packet_state();
        seq_expected  = '0;
        header_seen   = '0;
        length_field  = '0;
        data_received = '0;
        data_stored   = '0;
        frame_active  = 1'b0;
    endfunction

    // Advances the predictor by one accepted word and queues the result it causes.
    function automatic void reassemble_byte(t_in_word w);
        logic                wr_valid;
        logic                pkt_done;
        logic                seq_err;
        logic                dropped;
        logic [OFFS_W-1:0]   wr_offset;
        logic [PBYTES_W-1:0] done_bytes;
        logic [CFG_W-1:0]    cap;
        t_out_word           res;
        wr_valid   = 1'b0;
        pkt_done   = 1'b0;
        seq_err    = 1'b0;
        dropped    = 1'b0;
        wr_offset  = '0;
        done_bytes = '0;
        cap = (capacity_setting > MAX_STORED) ? MAX_STORED : capacity_setting;

        if (w.frame_first) begin
            frame_active = 1'b0;
            // While discarding, only a frame with sequence zero is looked at.
            if (discarding && w.rx_byte != '0) begin
                return;
            end
            discarding = 1'b0;
            if (w.rx_byte != seq_expected) begin
                clear_packet_state();
                discarding = 1'b1;
                seq_err = 1'b1;
            end else begin
                seq_expected = seq_expected + 1'b1;
                frame_active = 1'b1;
            end
        end else begin
            if (!frame_active) begin
                return;
            end
            if (header_seen < HDR_BYTES) begin
                length_field = length_field | ({24'd0, w.rx_byte} << (8 * header_seen));
                header_seen = header_seen + 1'b1;
            end else begin
                if (data_received != '1) begin
                    data_received = data_received + 1;
                end
                if (data_stored < cap) begin
                    wr_valid  = 1'b1;
                    wr_offset = data_stored[OFFS_W-1:0];
                    data_stored = data_stored + 1'b1;
                end else begin
                    dropped = 1'b1;
                end
            end
        end

        // Completion is only judged at the end of an open frame.
        if (w.frame_last && frame_active) begin
            frame_active = 1'b0;
            if (header_seen >= HDR_BYTES && data_received >= length_field) begin
                pkt_done   = 1'b1;
                done_bytes = data_stored;
                clear_packet_state();
            end
        end

        if (wr_valid || pkt_done || seq_err || dropped) begin
            res.write_valid  = wr_valid;
            res.write_byte   = wr_valid ? w.rx_byte : '0;
            res.write_offset = wr_offset;
            res.packet_done  = pkt_done;
            res.packet_bytes = done_bytes;
            res.out_of_sync  = seq_err;
            res.overflow     = dropped;
            predicted_results.push_back(res);
        end
    endfunction

    // Sender: presents queued words, holds them while stalled and idles at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                reassemble_byte('{i_rx_byte, i_frame_first, i_frame_last});
            end
            if (!i_in_valid || !o_in_stall) begin
                if (rx_frame_bytes.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    next_word = rx_frame_bytes.pop_front();
                    i_in_valid    <= 1'b1;
                    i_rx_byte     <= next_word.rx_byte;
                    i_frame_first <= next_word.frame_first;
                    i_frame_last  <= next_word.frame_last;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, logic [31:0] expv, logic [31:0] actv);
        if (actv !== expv) begin
            $error("%s: expected %0d, got %0d", name, expv, actv);
            n_errors++;
        end
    endtask

    // Receiver: checks each accepted result word against the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (predicted_results.size() == 0) begin
                    $error("result word with no prediction waiting");
                    n_errors++;
                end else begin
                    oldest_result = predicted_results.pop_front();
                    check_field("write_valid", oldest_result.write_valid, o_write_valid);
                    check_field("write_byte", oldest_result.write_byte, o_write_byte);
                    check_field("write_offset", oldest_result.write_offset, o_write_offset);
                    check_field("packet_done", oldest_result.packet_done, o_packet_done);
                    check_field("packet_bytes", oldest_result.packet_bytes, o_packet_bytes);
                    check_field("out_of_sync", oldest_result.out_of_sync, o_out_of_sync);
                    check_field("overflow", oldest_result.overflow, o_overflow);
                end
            end
            i_out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
        end
    end

    task automatic push_word(int unsigned b, bit first, bit last);
        t_in_word w;
        w.rx_byte     = 8'(b);
        w.frame_first = first;
        w.frame_last  = last;
        rx_frame_bytes.push_back(w);
    endtask

    // Sends one packet as frames of random size, numbered from zero, until it
    // completes, its bytes run out or 200 frames have been sent.
    task automatic send_packet(logic [31:0] hdr, int data_cnt, int max_chunk);
        logic [7:0] body[$];
        int         total;
        int         idx;
        int         chunk;
        int         seq;
        for (int i = 0; i < 4; i++) begin
            body.push_back(hdr[8*i +: 8]);
        end
        for (int i = 0; i < data_cnt; i++) begin
            body.push_back(8'($urandom_range(0, 255)));
        end
        total = body.size();
        idx = 0;
        seq = 0;
        while (idx < total && seq < 200) begin
            chunk = $urandom_range(0, max_chunk);
            if (chunk > total - idx) begin
                chunk = total - idx;
            end
            push_word(seq, 1'b1, chunk == 0);
            for (int i = 0; i < chunk; i++) begin
                push_word(body[idx + i], 1'b0, i == chunk - 1);
            end
            idx += chunk;
            seq++;
            if (idx >= 4 && longint'(idx - 4) >= longint'(hdr)) begin
                break;
            end
        end
    endtask

    // Mostly well-formed packets, the rest truncated, oversized or noise.
    task automatic random_traffic(int target);
        int r;
        int len;
        while (rx_frame_bytes.size() < target) begin
            r = $urandom_range(0, 99);
            if (r < 68) begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 40)
                                                   : $urandom_range(0, 12);
                send_packet(len, len, $urandom_range(1, 6));
            end else if (r < 80) begin
                len = $urandom_range(3, 12);
                send_packet(len, $urandom_range(0, len - 1), $urandom_range(1, 6));
            end else if (r < 88) begin
                send_packet($urandom() | 32'h0000_0100, $urandom_range(0, 3), 4);
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    push_word($urandom_range(0, 255), $urandom_range(0, 3) == 0,
                              $urandom_range(0, 2) == 0);
                end
            end
        end
    endtask

    // Waits until every word is sent and every result checked, then lets the pipe empty.
    task automatic drain();
        while (rx_frame_bytes.size() != 0 || i_in_valid || predicted_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        capacity_setting = value;
    endtask

    // Run a fixed-time watchdog beside the stimulus.
    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Stimulus: directed frames, then random phases over several capacities.
    initial begin
        logic [CFG_W-1:0] caps[6];
        caps = '{15'd32767, 15'd2, 15'd16384, 15'd5, 15'd1, 15'd11};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        tx_idle_pct  = 13;
        rx_stall_pct = 76;

        // A stray word with no frame open is ignored.
        push_word(8'hFF, 1'b0, 1'b1);
        // A two-byte packet in a single frame.
        push_word(0, 1'b1, 1'b0);
        push_word(2, 1'b0, 1'b0);
        push_word(0, 1'b0, 1'b0);
        push_word(0, 1'b0, 1'b0);
        push_word(0, 1'b0, 1'b0);
        push_word(8'h00, 1'b0, 1'b0);
        push_word(8'hFF, 1'b0, 1'b1);
        // A frame holding only its sequence byte, then an empty packet.
        push_word(0, 1'b1, 1'b1);
        push_word(1, 1'b1, 1'b0);
        push_word(0, 1'b0, 1'b0);
        push_word(0, 1'b0, 1'b0);
        push_word(0, 1'b0, 1'b0);
        push_word(0, 1'b0, 1'b1);
        // Wrong sequence, a frame ignored while discarding, then recovery.
        push_word(8'h05, 1'b1, 1'b0);
        push_word(8'h33, 1'b0, 1'b1);
        push_word(8'h03, 1'b1, 1'b1);
        push_word(0, 1'b1, 1'b0);
        push_word(1, 1'b0, 1'b0);
        push_word(0, 1'b0, 1'b0);
        push_word(0, 1'b0, 1'b0);
        push_word(0, 1'b0, 1'b0);
        push_word(8'hAB, 1'b0, 1'b1);
        // A new frame starts while the previous one is still open.
        push_word(0, 1'b1, 1'b0);
        push_word(1, 1'b0, 1'b0);
        push_word(0, 1'b0, 1'b0);
        push_word(0, 1'b0, 1'b0);
        push_word(1, 1'b1, 1'b0);
        push_word(0, 1'b0, 1'b0);
        push_word(8'hCD, 1'b0, 1'b1);
        drain();

        // With no capacity every data byte is dropped.
        write_capacity(15'd0);
        push_word(0, 1'b1, 1'b0);
        push_word(2, 1'b0, 1'b0);
        push_word(0, 1'b0, 1'b0);
        push_word(0, 1'b0, 1'b0);
        push_word(0, 1'b0, 1'b0);
        push_word(8'h11, 1'b0, 1'b0);
        push_word(8'h22, 1'b0, 1'b1);
        drain();

        for (int p = 0; p < 6; p++) begin
            if (p < 2) begin
                tx_idle_pct  = 13;
                rx_stall_pct = 76;
            end else if (p < 4) begin
                tx_idle_pct  = 76;
                rx_stall_pct = 13;
            end else begin
                tx_idle_pct  = 0;
                rx_stall_pct = 0;
            end
            write_capacity(caps[p]);
            random_traffic(60);
            drain();
        end

        if (n_errors == 0 && predicted_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+design
design/lpr_pkg.sv
design/lpr_in_stage.sv
design/lpr_core.sv
design/lpr_out_stage.sv
design/link_packet_reassembler.sv
sim/tb_link_packet_reassembler.sv
